// ----- hw/rtl/udprff_pkg.sv -----
// Shared constants, types and helpers for the UDP result frame filter.
package udprff_pkg;

   localparam int VALUES_PER_FRAME = 64;
   localparam int MAX_FRAME_BYTES  = 2048;
   localparam int COUNTER_BITS     = 32;

   localparam int POS_BITS   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int DONE_BITS  = $clog2(VALUES_PER_FRAME + 1);
   localparam int SPAN_BITS  = $clog2(MAX_FRAME_BYTES + 8 * VALUES_PER_FRAME + 128) + 1;
   localparam int IHB_BITS   = 6;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [3:0]  IHL_MASK       = 4'hF;
   localparam logic [IHB_BITS-1:0] MIN_IHL_BYTES = 6'd20;
   localparam logic [15:0] PORT_AT_RESET  = 16'h2345;

   localparam int ETH_HDR_BYTES = 14;
   localparam int UDP_HDR_BYTES = 8;
   localparam int ROUND_BYTES   = 2;
   localparam int POS_TYPE_HI   = 12;
   localparam int POS_TYPE_LO   = 13;
   localparam int POS_IHL       = 14;
   localparam int POS_PROTO     = 23;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_HOST   = 2'd1,
      VERDICT_REJECT = 2'd2
   } verdict_type;

   typedef enum logic {
      KIND_VALUE   = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic       sent_by_host;
      logic       clear_counts;
   } req_item_type;

   typedef struct packed {
      logic        item_kind;
      logic [6:0]  entry_index;
      logic [63:0] entry_value;
      logic [15:0] frame_round;
      logic [1:0]  verdict;
      logic [31:0] total_frames;
      logic [31:0] outgoing_frames;
      logic [31:0] rejected_frames;
      logic        run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type slot0;
      rsp_item_type slot1;
   } push_type;

   typedef struct packed {
      logic frame_idle;
   } parse_stat_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 room;
   } queue_stat_type;

   function automatic logic [31:0] count_out(input logic [COUNTER_BITS-1:0] c);
      logic [95:0] w;
      w = 96'(c);
      return w[31:0];
   endfunction

   function automatic logic [6:0] index_out(input logic [DONE_BITS-1:0] d);
      logic [15:0] w;
      w = 16'(d);
      return w[6:0];
   endfunction

endpackage

// ----- hw/rtl/udprff_if.sv -----
// Request and response channel interfaces of the UDP result frame filter.
interface udprff_req_if import udprff_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;
   logic       sent_by_host;
   logic       clear_counts;

   modport source (output valid, frame_byte, frame_end, sent_by_host, clear_counts,
                   input ready);
   modport sink (input valid, frame_byte, frame_end, sent_by_host, clear_counts,
                 output ready);
endinterface

interface udprff_rsp_if import udprff_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [6:0]  entry_index;
   logic [63:0] entry_value;
   logic [15:0] frame_round;
   logic [1:0]  verdict;
   logic [31:0] total_frames;
   logic [31:0] outgoing_frames;
   logic [31:0] rejected_frames;
   logic        run_last;

   modport source (output valid, item_kind, entry_index, entry_value, frame_round, verdict,
                   total_frames, outgoing_frames, rejected_frames, run_last,
                   input ready);
   modport sink (input valid, item_kind, entry_index, entry_value, frame_round, verdict,
                 total_frames, outgoing_frames, rejected_frames, run_last,
                 output ready);
endinterface

// ----- hw/rtl/udprff_parser.sv -----
// Per-byte frame parser: header checks, value assembly, verdict and counters.
module udprff_parser import udprff_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_item_type   item,
   input  logic [15:0]    udp_port,
   output push_type       push,
   output parse_stat_type stat
);

   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [IHB_BITS-1:0]     ihb_ff, ihb_in;
   logic                    checks_ff, checks_in;
   logic                    outgoing_ff, outgoing_in;
   logic [63:0]             shift_ff, shift_in;
   logic [15:0]             round_ff, round_in;
   logic [DONE_BITS-1:0]    done_ff, done_in;
   logic [COUNTER_BITS-1:0] tot_ff, tot_in;
   logic [COUNTER_BITS-1:0] out_ff, out_in;
   logic [COUNTER_BITS-1:0] rej_ff, rej_in;

   logic                    first;
   logic [7:0]              b;
   logic [SPAN_BITS-1:0]    p_w, u_w, q_w, lo_w, hi_w, k_w, need_w, pnew_w;
   logic                    value_hit;
   logic [COUNTER_BITS-1:0] tot_cur, out_cur, rej_cur;
   logic [COUNTER_BITS-1:0] cnt_one;
   verdict_type             vd;
   logic [15:0]             vd_round;
   rsp_item_type            value_item, verdict_item;

   always_comb begin
      b       = item.frame_byte;
      first   = (pos_ff == '0);
      cnt_one = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

      tot_cur     = (first && item.clear_counts) ? '0 : tot_ff;
      out_cur     = (first && item.clear_counts) ? '0 : out_ff;
      rej_cur     = (first && item.clear_counts) ? '0 : rej_ff;
      outgoing_in = first ? item.sent_by_host : outgoing_ff;
      checks_in   = first ? 1'b1 : checks_ff;
      ihb_in      = first ? '0 : ihb_ff;
      shift_in    = first ? '0 : shift_ff;
      round_in    = first ? '0 : round_ff;
      done_in     = first ? '0 : done_ff;
      pos_in      = pos_ff;
      value_hit   = 1'b0;

      p_w  = SPAN_BITS'(pos_ff);
      u_w  = '0;
      q_w  = '0;
      lo_w = '0;
      hi_w = '0;
      k_w  = '0;

      if (pos_ff < POS_BITS'(MAX_FRAME_BYTES)) begin
         if (p_w == SPAN_BITS'(POS_TYPE_HI) && b != ETHERTYPE_IPV4[15:8]) begin
            checks_in = 1'b0;
         end
         if (p_w == SPAN_BITS'(POS_TYPE_LO) && b != ETHERTYPE_IPV4[7:0]) begin
            checks_in = 1'b0;
         end
         if (p_w == SPAN_BITS'(POS_IHL)) begin
            ihb_in = {b[3:0] & IHL_MASK, 2'b00};
            if (ihb_in < MIN_IHL_BYTES) begin
               checks_in = 1'b0;
            end
         end
         if (p_w == SPAN_BITS'(POS_PROTO) && b != PROTO_UDP) begin
            checks_in = 1'b0;
         end
         u_w  = SPAN_BITS'(ETH_HDR_BYTES) + SPAN_BITS'(ihb_in);
         q_w  = u_w + SPAN_BITS'(UDP_HDR_BYTES);
         lo_w = q_w + SPAN_BITS'(ROUND_BYTES);
         hi_w = lo_w + SPAN_BITS'(8 * VALUES_PER_FRAME);
         k_w  = p_w - lo_w;
         if (p_w > SPAN_BITS'(POS_IHL) && checks_in) begin
            if (p_w == u_w + SPAN_BITS'(2) && b != udp_port[15:8]) begin
               checks_in = 1'b0;
            end
            if (p_w == u_w + SPAN_BITS'(3) && b != udp_port[7:0]) begin
               checks_in = 1'b0;
            end
            if (p_w == q_w) begin
               round_in = {b, 8'h00};
            end
            if (p_w == q_w + SPAN_BITS'(1)) begin
               round_in = {round_in[15:8], b};
            end
            if (checks_in && p_w >= lo_w && p_w < hi_w) begin
               shift_in = {shift_in[55:0], b};
               if (k_w[2:0] == 3'b111) begin
                  done_in   = done_in + {{(DONE_BITS-1){1'b0}}, 1'b1};
                  value_hit = !outgoing_in;
               end
            end
         end
         pos_in = pos_ff + {{(POS_BITS-1){1'b0}}, 1'b1};
      end

      pnew_w = SPAN_BITS'(pos_in);
      need_w = SPAN_BITS'(ETH_HDR_BYTES + UDP_HDR_BYTES + ROUND_BYTES + 8 * VALUES_PER_FRAME)
               + SPAN_BITS'(ihb_in);

      tot_in   = tot_cur;
      out_in   = out_cur;
      rej_in   = rej_cur;
      vd       = VERDICT_ACCEPT;
      vd_round = '0;
      if (item.frame_end) begin
         tot_in = tot_cur + cnt_one;
         if (outgoing_in) begin
            out_in = out_cur + cnt_one;
            vd     = VERDICT_HOST;
         end else if (checks_in && ihb_in >= MIN_IHL_BYTES && pnew_w >= need_w) begin
            vd_round = round_in;
         end else begin
            rej_in = rej_cur + cnt_one;
            vd     = VERDICT_REJECT;
         end
         pos_in = '0;
      end

      value_item.item_kind       = KIND_VALUE;
      value_item.entry_index     = index_out(done_in);
      value_item.entry_value     = shift_in;
      value_item.frame_round     = round_in;
      value_item.verdict         = VERDICT_ACCEPT;
      value_item.total_frames    = count_out(tot_cur);
      value_item.outgoing_frames = count_out(out_cur);
      value_item.rejected_frames = count_out(rej_cur);
      value_item.run_last        = !item.frame_end;

      verdict_item.item_kind       = KIND_VERDICT;
      verdict_item.entry_index     = '0;
      verdict_item.entry_value     = '0;
      verdict_item.frame_round     = vd_round;
      verdict_item.verdict         = vd;
      verdict_item.total_frames    = count_out(tot_in);
      verdict_item.outgoing_frames = count_out(out_in);
      verdict_item.rejected_frames = count_out(rej_in);
      verdict_item.run_last        = 1'b1;

      push.slot0 = value_hit ? value_item : verdict_item;
      push.slot1 = verdict_item;
      if (!fire) begin
         push.count = 2'd0;
      end else begin
         push.count = 2'({1'b0, value_hit} + {1'b0, item.frame_end});
      end
      stat.frame_idle = first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         ihb_ff      <= '0;
         checks_ff   <= 1'b1;
         outgoing_ff <= 1'b0;
         shift_ff    <= '0;
         round_ff    <= '0;
         done_ff     <= '0;
         tot_ff      <= '0;
         out_ff      <= '0;
         rej_ff      <= '0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         ihb_ff      <= ihb_in;
         checks_ff   <= checks_in;
         outgoing_ff <= outgoing_in;
         shift_ff    <= shift_in;
         round_ff    <= round_in;
         done_ff     <= done_in;
         tot_ff      <= tot_in;
         out_ff      <= out_in;
         rej_ff      <= rej_in;
      end
   end

endmodule

// ----- hw/rtl/udprff_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
module udprff_queue import udprff_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  push_type       push,
   input  logic           pop,
   output logic           head_valid,
   output rsp_item_type   head,
   output queue_stat_type stat
);

   rsp_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in;
   logic [QPTR_BITS-1:0] rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic [QPTR_BITS-1:0] wr_next;

   always_comb begin
      wr_next    = wr_ff + {{(QPTR_BITS-1){1'b0}}, 1'b1};
      wr_in      = wr_ff + QPTR_BITS'(push.count);
      rd_in      = pop ? rd_ff + {{(QPTR_BITS-1){1'b0}}, 1'b1} : rd_ff;
      cnt_in     = cnt_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
      head_valid = (cnt_ff != '0);
      head       = mem_ff[rd_ff];
      stat.count = cnt_ff;
      stat.room  = (cnt_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/udp_result_frame_filter.sv -----
// Top level of the UDP result frame filter.
// Usage:
//   req_if carries one frame byte per request, with frame_end on the last byte and
//   sent_by_host / clear_counts sampled on the first byte of a frame.
//   rsp_if delivers payload value entries as their eighth byte arrives and one
//   verdict per frame; run_last marks the last response caused by a request.
//   csr_wr_en / csr_wr_data load the UDP destination port (reset 0x2345); write
//   it only while no frame is in progress and all responses are taken.
// Timing:
//   A request enters an input register and is parsed from there once the queue
//   has room for two responses; its responses land in a four-entry response
//   queue whose head drives rsp_if. One request per cycle is taken while the
//   queue has room for two responses; the response side drains one entry per
//   cycle while rsp_if.ready is high.
// Reset clears the frame position, the counters and the queue.
// When the receiver stalls, the queue fills and req_if.ready drops until room
// for two responses opens up again.
module udp_result_frame_filter import udprff_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   udprff_req_if.sink   req_if,
   udprff_rsp_if.source rsp_if,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   logic [15:0]    port_ff;
   logic           stage_valid_ff, stage_valid_in;
   req_item_type   stage_item_ff;
   logic           req_fire;
   logic           stage_adv;
   logic           pop;
   push_type       push;
   parse_stat_type p_stat;
   queue_stat_type q_stat;
   logic           head_valid;
   rsp_item_type   head;

   always_comb begin
      stage_adv      = stage_valid_ff && q_stat.room;
      req_if.ready   = !stage_valid_ff || q_stat.room;
      req_fire       = req_if.valid && req_if.ready;
      stage_valid_in = req_fire || (stage_valid_ff && !stage_adv);
      pop            = head_valid && rsp_if.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff        <= PORT_AT_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_wr_en) begin
            port_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_item_ff.frame_byte   <= req_if.frame_byte;
         stage_item_ff.frame_end    <= req_if.frame_end;
         stage_item_ff.sent_by_host <= req_if.sent_by_host;
         stage_item_ff.clear_counts <= req_if.clear_counts;
      end
   end

   udprff_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (stage_adv),
      .item     (stage_item_ff),
      .udp_port (port_ff),
      .push     (push),
      .stat     (p_stat)
   );

   udprff_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .stat       (q_stat)
   );

   assign rsp_if.valid           = head_valid;
   assign rsp_if.item_kind       = head.item_kind;
   assign rsp_if.entry_index     = head.entry_index;
   assign rsp_if.entry_value     = head.entry_value;
   assign rsp_if.frame_round     = head.frame_round;
   assign rsp_if.verdict         = head.verdict;
   assign rsp_if.total_frames    = head.total_frames;
   assign rsp_if.outgoing_frames = head.outgoing_frames;
   assign rsp_if.rejected_frames = head.rejected_frames;
   assign rsp_if.run_last        = head.run_last;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("response queue overflow");

   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> q_stat.room)
      else $error("two responses pushed without room");

   a_end_verdict: assert property (@(posedge clock) disable iff (reset)
      stage_adv && stage_item_ff.frame_end |-> push.count != 2'd0)
      else $error("frame end without verdict");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      stage_adv && stage_item_ff.frame_end |=> p_stat.frame_idle)
      else $error("frame position not rewound after frame end");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the UDP result frame filter: byte-level predictor, directed steps, random frames.
`timescale 1ns / 100ps

module tb;
   import udprff_pkg::*;

   localparam int CYCLE_LIMIT   = 20000;
   localparam int PAYLOAD_BYTES = 8 * VALUES_PER_FRAME;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 20;

   typedef enum int {
      FR_GOOD,
      FR_SHORT,
      FR_NOISE,
      FR_BAD_TYPE_HI,
      FR_BAD_TYPE_LO,
      FR_BAD_IHL,
      FR_BAD_PROTO,
      FR_BAD_PORT_HI,
      FR_BAD_PORT_LO
   } frame_kind_type;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      verdict_type  verdict;
      logic [31:0]  total;
      logic [31:0]  outgoing;
      logic [31:0]  rejected;
   } step_row_type;

   localparam step_row_type STEP_TABLE [21] = '{
      '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, VERDICT_REJECT, 32'd1, 32'd0, 32'd1},
      '{'{8'h00, 1'b1, 1'b1, 1'b0}, 1'b1, VERDICT_HOST,   32'd2, 32'd1, 32'd1},
      '{'{8'hA5, 1'b0, 1'b0, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h5A, 1'b1, 1'b1, 1'b1}, 1'b1, VERDICT_REJECT, 32'd1, 32'd0, 32'd1},
      '{'{8'h12, 1'b1, 1'b1, 1'b0}, 1'b1, VERDICT_HOST,   32'd2, 32'd1, 32'd1},
      '{'{8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'hFF, 1'b0, 1'b1, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'hFF, 1'b0, 1'b0, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'hFF, 1'b0, 1'b1, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'hFF, 1'b0, 1'b1, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h7F, 1'b0, 1'b1, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h80, 1'b0, 1'b0, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h01, 1'b0, 1'b1, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'hFE, 1'b0, 1'b0, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h08, 1'b0, 1'b0, 1'b1}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, VERDICT_ACCEPT, 32'd0, 32'd0, 32'd0},
      '{'{8'h44, 1'b1, 1'b0, 1'b1}, 1'b1, VERDICT_REJECT, 32'd3, 32'd1, 32'd2},
      '{'{8'h80, 1'b1, 1'b0, 1'b1}, 1'b1, VERDICT_REJECT, 32'd1, 32'd0, 32'd1}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   udprff_req_if req_if ();
   udprff_rsp_if rsp_if ();

   udp_result_frame_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [15:0]  port_cfg;
   int unsigned  at_byte;
   logic [5:0]   ihl_bytes;
   logic         header_ok;
   logic         host_frame;
   logic [63:0]  value_acc;
   logic [15:0]  round_num;
   logic [6:0]   values_seen;
   logic [31:0]  frames_total;
   logic [31:0]  frames_out;
   logic [31:0]  frames_rej;

   rsp_item_type filtered_q [$];
   logic [7:0]   frame_bytes [$];
   int           mismatches;
   int           sent_items;
   bit           calm;
   int           hold_rsp_cycles;
   rsp_item_type got;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic filter_byte(input req_item_type it);
      int unsigned  udp_at;
      int unsigned  pay_at;
      int unsigned  need;
      int           n;
      rsp_item_type made [2];
      rsp_item_type r;
      n = 0;
      if (at_byte == 0) begin
         if (it.clear_counts) begin
            frames_total = '0;
            frames_out   = '0;
            frames_rej   = '0;
         end
         host_frame  = it.sent_by_host;
         header_ok   = 1'b1;
         ihl_bytes   = '0;
         value_acc   = '0;
         round_num   = '0;
         values_seen = '0;
      end
      if (at_byte < MAX_FRAME_BYTES) begin
         if (at_byte == POS_TYPE_HI && it.frame_byte != ETHERTYPE_IPV4[15:8])
            header_ok = 1'b0;
         if (at_byte == POS_TYPE_LO && it.frame_byte != ETHERTYPE_IPV4[7:0])
            header_ok = 1'b0;
         if (at_byte == POS_IHL) begin
            ihl_bytes = {it.frame_byte[3:0], 2'b00};
            if (ihl_bytes < MIN_IHL_BYTES)
               header_ok = 1'b0;
         end
         if (at_byte == POS_PROTO && it.frame_byte != PROTO_UDP)
            header_ok = 1'b0;
         if (at_byte > POS_IHL && header_ok) begin
            udp_at = ETH_HDR_BYTES + ihl_bytes;
            pay_at = udp_at + UDP_HDR_BYTES;
            if (at_byte == udp_at + 2 && it.frame_byte != port_cfg[15:8])
               header_ok = 1'b0;
            if (at_byte == udp_at + 3 && it.frame_byte != port_cfg[7:0])
               header_ok = 1'b0;
            if (at_byte == pay_at)
               round_num = {it.frame_byte, 8'h00};
            if (at_byte == pay_at + 1)
               round_num = {round_num[15:8], it.frame_byte};
            if (header_ok && at_byte >= pay_at + ROUND_BYTES &&
                at_byte < pay_at + ROUND_BYTES + PAYLOAD_BYTES) begin
               value_acc = {value_acc[55:0], it.frame_byte};
               if ((at_byte - pay_at - ROUND_BYTES) % 8 == 7) begin
                  values_seen++;
                  if (!host_frame) begin
                     r = '0;
                     r.item_kind       = KIND_VALUE;
                     r.entry_index     = values_seen;
                     r.entry_value     = value_acc;
                     r.frame_round     = round_num;
                     r.verdict         = VERDICT_ACCEPT;
                     r.total_frames    = frames_total;
                     r.outgoing_frames = frames_out;
                     r.rejected_frames = frames_rej;
                     made[n] = r;
                     n++;
                  end
               end
            end
         end
         at_byte++;
      end
      if (it.frame_end) begin
         need = ETH_HDR_BYTES + ihl_bytes + UDP_HDR_BYTES + ROUND_BYTES + PAYLOAD_BYTES;
         frames_total++;
         r = '0;
         r.item_kind = KIND_VERDICT;
         if (host_frame) begin
            frames_out++;
            r.verdict = VERDICT_HOST;
         end else if (header_ok && ihl_bytes >= MIN_IHL_BYTES && at_byte >= need) begin
            r.verdict     = VERDICT_ACCEPT;
            r.frame_round = round_num;
         end else begin
            frames_rej++;
            r.verdict = VERDICT_REJECT;
         end
         r.total_frames    = frames_total;
         r.outgoing_frames = frames_out;
         r.rejected_frames = frames_rej;
         made[n] = r;
         n++;
         at_byte = 0;
      end
      if (n > 0)
         made[n - 1].run_last = 1'b1;
      for (int i = 0; i < n; i++)
         filtered_q.push_back(made[i]);
   endtask

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] seen);
      if (seen !== want) begin
         mismatches++;
         $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, seen);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.item_kind       = rsp_if.item_kind;
         got.entry_index     = rsp_if.entry_index;
         got.entry_value     = rsp_if.entry_value;
         got.frame_round     = rsp_if.frame_round;
         got.verdict         = rsp_if.verdict;
         got.total_frames    = rsp_if.total_frames;
         got.outgoing_frames = rsp_if.outgoing_frames;
         got.rejected_frames = rsp_if.rejected_frames;
         got.run_last        = rsp_if.run_last;
         if (filtered_q.size() == 0) begin
            mismatches++;
            $display("%0t mismatch response: expected none, actual %h", $time, got);
         end else begin
            compare_field("item_kind", 64'(filtered_q[0].item_kind), 64'(got.item_kind));
            compare_field("entry_index", 64'(filtered_q[0].entry_index),
                          64'(got.entry_index));
            compare_field("entry_value", filtered_q[0].entry_value, got.entry_value);
            compare_field("frame_round", 64'(filtered_q[0].frame_round),
                          64'(got.frame_round));
            compare_field("verdict", 64'(filtered_q[0].verdict), 64'(got.verdict));
            compare_field("total_frames", 64'(filtered_q[0].total_frames),
                          64'(got.total_frames));
            compare_field("outgoing_frames", 64'(filtered_q[0].outgoing_frames),
                          64'(got.outgoing_frames));
            compare_field("rejected_frames", 64'(filtered_q[0].rejected_frames),
                          64'(got.rejected_frames));
            compare_field("run_last", 64'(filtered_q[0].run_last), 64'(got.run_last));
            void'(filtered_q.pop_front());
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_cycles > 0) begin
            hold_rsp_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 13);
         end
      end
   end

   task automatic send_byte(input req_item_type it);
      if (!calm) begin
         while ($urandom_range(99) < 13) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.frame_byte   <= it.frame_byte;
      req_if.frame_end    <= it.frame_end;
      req_if.sent_by_host <= it.sent_by_host;
      req_if.clear_counts <= it.clear_counts;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      filter_byte(it);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic drive_frame(input bit host);
      req_item_type it;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         it.frame_byte   = frame_bytes[i];
         it.frame_end    = (i == frame_bytes.size() - 1);
         it.sent_by_host = (i == 0) ? host : 1'($urandom);
         it.clear_counts = (i == 0) ? ($urandom_range(99) < 20) : 1'($urandom);
         send_byte(it);
      end
   endtask

   task automatic build_frame(input frame_kind_type kind, input int trail);
      int         ihl;
      int         udp_at;
      int         need;
      int         cut;
      logic [7:0] b;
      frame_bytes.delete();
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(40, 1))
            frame_bytes.push_back(8'($urandom));
         return;
      end
      ihl    = $urandom_range(15, 5);
      udp_at = ETH_HDR_BYTES + 4 * ihl;
      need   = udp_at + UDP_HDR_BYTES + ROUND_BYTES + PAYLOAD_BYTES;
      repeat (need + trail)
         frame_bytes.push_back(8'($urandom));
      frame_bytes[POS_TYPE_HI] = ETHERTYPE_IPV4[15:8];
      frame_bytes[POS_TYPE_LO] = ETHERTYPE_IPV4[7:0];
      b = frame_bytes[POS_IHL];
      frame_bytes[POS_IHL]    = {b[7:4], 4'(ihl)};
      frame_bytes[POS_PROTO]  = PROTO_UDP;
      frame_bytes[udp_at + 2] = port_cfg[15:8];
      frame_bytes[udp_at + 3] = port_cfg[7:0];
      if (kind == FR_GOOD)
         cut = need + trail;
      else
         cut = udp_at + UDP_HDR_BYTES + ROUND_BYTES + 8 * $urandom_range(3) + trail;
      b = 8'($urandom_range(255, 1));
      case (kind)
         FR_BAD_TYPE_HI: frame_bytes[POS_TYPE_HI] = ETHERTYPE_IPV4[15:8] ^ b;
         FR_BAD_TYPE_LO: frame_bytes[POS_TYPE_LO] = ETHERTYPE_IPV4[7:0] ^ b;
         FR_BAD_IHL: frame_bytes[POS_IHL] = {b[7:4], 4'($urandom_range(4))};
         FR_BAD_PROTO: frame_bytes[POS_PROTO] = PROTO_UDP ^ b;
         FR_BAD_PORT_HI: frame_bytes[udp_at + 2] = port_cfg[15:8] ^ b;
         FR_BAD_PORT_LO: frame_bytes[udp_at + 3] = port_cfg[7:0] ^ b;
         FR_SHORT: cut = $urandom_range(udp_at + UDP_HDR_BYTES + ROUND_BYTES + 24, 15);
         default: ;
      endcase
      while (frame_bytes.size() > cut)
         frame_bytes.delete(frame_bytes.size() - 1);
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 35)
         return FR_SHORT;
      if (r < 55)
         return FR_NOISE;
      return frame_kind_type'(FR_BAD_TYPE_HI + r % 6);
   endfunction

   task automatic write_port(input logic [15:0] value);
      req_if.valid <= 1'b0;
      while (filtered_q.size() != 0)
         @(posedge clock);
      repeat (4)
         @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      port_cfg = value;
   endtask

   initial begin
      rsp_item_type   r;
      logic [15:0]    port_val;
      int             phase_end;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_if.valid        = 1'b0;
      req_if.frame_byte   = '0;
      req_if.frame_end    = 1'b0;
      req_if.sent_by_host = 1'b0;
      req_if.clear_counts = 1'b0;
      mismatches          = 0;
      sent_items          = 0;
      calm                = 1'b0;
      hold_rsp_cycles     = 0;
      port_cfg            = PORT_AT_RESET;
      at_byte             = 0;
      ihl_bytes           = '0;
      header_ok           = 1'b1;
      host_frame          = 1'b0;
      value_acc           = '0;
      round_num           = '0;
      values_seen         = '0;
      frames_total        = '0;
      frames_out          = '0;
      frames_rej          = '0;
      repeat (3)
         @(negedge clock);
      reset <= 1'b0;

      foreach (STEP_TABLE[i]) begin
         send_byte(STEP_TABLE[i].item);
         if (STEP_TABLE[i].typed) begin
            r = '0;
            r.item_kind       = KIND_VERDICT;
            r.verdict         = STEP_TABLE[i].verdict;
            r.total_frames    = STEP_TABLE[i].total;
            r.outgoing_frames = STEP_TABLE[i].outgoing;
            r.rejected_frames = STEP_TABLE[i].rejected;
            r.run_last        = 1'b1;
            filtered_q[filtered_q.size() - 1] = r;
         end
      end

      // stall the receiver so the response queue fills mid-payload
      hold_rsp_cycles = HOLD_CYCLES;
      calm = 1'b1;
      build_frame(FR_GOOD, 0);
      drive_frame(1'b0);
      calm = 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: port_val = 16'hFFFF;
            1: port_val = 16'h0000;
            2: port_val = 16'($urandom);
            default: port_val = PORT_AT_RESET;
         endcase
         write_port(port_val);
         phase_end = sent_items + PHASE_ITEMS;
         do begin
            build_frame(pick_kind(), $urandom_range(8));
            drive_frame($urandom_range(99) < 15);
         end while (sent_items < phase_end);
      end

      req_if.valid <= 1'b0;
      while (filtered_q.size() != 0)
         @(posedge clock);
      repeat (8)
         @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
